// ===== hdl/cfs_pkg.sv =====
// circle fill span package: configuration register indexes and fixed constants
// used by the span generator top level; depends on nothing
`default_nettype none

package cfs_pkg;

	localparam int CFG_ADDR_W = 2;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_RADIUS   = 2'd2
	} cfg_reg_t;

	localparam int RADIUS_RESET = 50;

endpackage

`default_nettype wire

// ===== hdl/circle_fill_span.sv =====
// filled-circle scanline span generator: one span per row offset, fully pipelined
// exact floor square root, one root bit per stage; depends on cfs_pkg
//
// usage: write center_x (0), center_y (1) and circle_radius (2) on the cfg port
// while the block is idle, then stream signed row offsets into the s_axis side.
// each input transaction gives exactly one output transaction on m_axis with
// row_y = center_y + dy, left_x = center_x - s, right_x = center_x + s, where
// s = floor(sqrt(r*r - dy*dy)); when |dy| > r the outside flag (tuser) is set
// and all three span fields are zero.
// pipeline stages in order: one for offset magnitude and range check, one for
// the two squares, one for the difference, one per root bit in the square root
// chain, and the output register.
// throughput is one row per cycle unless m_tready stalls; each stage holds its own valid bit, so a
// stall on m_tready only backs up as far as the first empty stage and the
// input keeps taking rows into any bubbles. nothing is lost or repeated.
// reset clears all valid bits and loads center 0,0 and radius 50.
`default_nettype none

module circle_fill_span
	import cfs_pkg::*;
#(
	parameter int COORD_BITS  = 12,
	parameter int RADIUS_BITS = 11
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration write port
	input  wire logic                                   cfg_wen,
	input  wire logic [CFG_ADDR_W-1:0]                  cfg_addr,
	input  wire logic [((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS)-1:0] cfg_wdata,
	// input rows
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// bits up: row_offset, zero pad
	input  wire logic [((RADIUS_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,
	// output spans
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// bits up: row_y, left_x, right_x, zero pad
	output logic [((2 * (COORD_BITS + 2) + COORD_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
	// bits up: outside
	output logic                                        m_tuser
);

	localparam int OFF_W   = RADIUS_BITS + 1;
	localparam int ROW_W   = COORD_BITS + 2;
	localparam int RIGHT_W = COORD_BITS + 1;
	localparam int SQ_W    = 2 * RADIUS_BITS;
	localparam int NSQ     = RADIUS_BITS;
	localparam int SUM_W   = ((ROW_W > RADIUS_BITS + 2) ? ROW_W : RADIUS_BITS + 2) + 1;
	localparam int OUT_W   = 2 * ROW_W + RIGHT_W;
	localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8 - OUT_W;

	// configuration registers
	logic [COORD_BITS-1:0]  center_x_q;
	logic [COORD_BITS-1:0]  center_y_q;
	logic [RADIUS_BITS-1:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= RADIUS_BITS'(RADIUS_RESET);
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_CENTER_X: center_x_q <= cfg_wdata[COORD_BITS-1:0];
				REG_CENTER_Y: center_y_q <= cfg_wdata[COORD_BITS-1:0];
				REG_RADIUS:   radius_q   <= cfg_wdata[RADIUS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// pipeline registers
	logic                   v_s1, v_s2;
	logic [OFF_W-1:0]       dy_s1, dy_s2;
	logic [OFF_W-1:0]       mag_s1;
	logic                   out_s1, out_s2;
	logic [SQ_W-1:0]        rr_s2, mm_s2;

	// square root chain, index 0 holds the difference, index k has k root bits done
	logic                   v_sk   [0:NSQ];
	logic [OFF_W-1:0]       dy_sk  [0:NSQ];
	logic                   out_sk [0:NSQ];
	logic [SQ_W-1:0]        rem_sk [0:NSQ];
	logic [SQ_W-1:0]        root_sk[0:NSQ];

	logic                   rdy_out, rdy1, rdy2;
	logic                   rdy_sk [0:NSQ];

	logic [OFF_W-1:0]       dy_in;
	logic [OFF_W-1:0]       mag_in;

	logic [ROW_W-1:0]       row_q;
	logic [ROW_W-1:0]       left_q;
	logic [RIGHT_W-1:0]     right_q;
	logic                   outside_q;

	// a stage takes new data when it is empty or its content moves on
	assign rdy_out = !m_tvalid || m_tready;
	assign rdy_sk[NSQ] = !v_sk[NSQ] || rdy_out;
	for (genvar k = 0; k < NSQ; k++) begin : g_rdy
		assign rdy_sk[k] = !v_sk[k] || rdy_sk[k+1];
	end
	assign rdy2 = !v_s2 || rdy_sk[0];
	assign rdy1 = !v_s1 || rdy2;
	assign s_tready = rdy1;

	// stage 1: offset magnitude and range check
	assign dy_in  = s_tdata[OFF_W-1:0];
	assign mag_in = dy_in[OFF_W-1] ? (~dy_in + OFF_W'(1)) : dy_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			dy_s1  <= dy_in;
			mag_s1 <= mag_in;
			out_s1 <= mag_in > {1'b0, radius_q};
		end
	end

	// stage 2: both squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			dy_s2  <= dy_s1;
			out_s2 <= out_s1;
			rr_s2  <= SQ_W'(radius_q) * SQ_W'(radius_q);
			mm_s2  <= SQ_W'(mag_s1[RADIUS_BITS-1:0]) * SQ_W'(mag_s1[RADIUS_BITS-1:0]);
		end
	end

	// stage 3: radicand, wraps when outside but the span is zeroed then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk[0] <= 1'b0;
		end else if (rdy_sk[0]) begin
			v_sk[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_sk[0] && v_s2) begin
			dy_sk[0]   <= dy_s2;
			out_sk[0]  <= out_s2;
			rem_sk[0]  <= rr_s2 - mm_s2;
			root_sk[0] <= '0;
		end
	end

	// one root bit per stage, trial bit walks down two places each time
	for (genvar k = 1; k <= NSQ; k++) begin : g_sqrt
		localparam logic [SQ_W-1:0] TRIAL = SQ_W'(1) << (2 * (NSQ - k));

		logic [SQ_W:0] sum;
		logic          take;

		assign sum  = {1'b0, root_sk[k-1]} + {1'b0, TRIAL};
		assign take = {1'b0, rem_sk[k-1]} >= sum;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k] <= 1'b0;
			end else if (rdy_sk[k]) begin
				v_sk[k] <= v_sk[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_sk[k] && v_sk[k-1]) begin
				dy_sk[k]  <= dy_sk[k-1];
				out_sk[k] <= out_sk[k-1];
				if (take) begin
					rem_sk[k]  <= rem_sk[k-1] - sum[SQ_W-1:0];
					root_sk[k] <= (root_sk[k-1] >> 1) + TRIAL;
				end else begin
					rem_sk[k]  <= rem_sk[k-1];
					root_sk[k] <= root_sk[k-1] >> 1;
				end
			end
		end
	end

	// output register: row and span edges
	logic [SUM_W-1:0] row_sum, left_sum, right_sum, half_w;

	assign half_w    = SUM_W'(root_sk[NSQ][RADIUS_BITS-1:0]);
	assign row_sum   = SUM_W'(center_y_q)
	                 + {{(SUM_W - OFF_W){dy_sk[NSQ][OFF_W-1]}}, dy_sk[NSQ]};
	assign left_sum  = SUM_W'(center_x_q) - half_w;
	assign right_sum = SUM_W'(center_x_q) + half_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (rdy_out) begin
			m_tvalid <= v_sk[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_sk[NSQ]) begin
			outside_q <= out_sk[NSQ];
			if (out_sk[NSQ]) begin
				row_q   <= '0;
				left_q  <= '0;
				right_q <= '0;
			end else begin
				row_q   <= row_sum[ROW_W-1:0];
				left_q  <= left_sum[ROW_W-1:0];
				right_q <= right_sum[RIGHT_W-1:0];
			end
		end
	end

	// zero pad above the three span fields
	assign m_tdata = (OUT_W + OUT_PAD)'({right_q, left_q, row_q});
	assign m_tuser = outside_q;

endmodule

`default_nettype wire

// ===== tb/sv/circle_fill_span_test.sv =====
// self-checking testbench for circle_fill_span: random and directed row offsets,
// spans predicted in the bench and compared per field; depends on cfs_pkg and the dut
`timescale 1ns / 1ps

module circle_fill_span_test;
	import cfs_pkg::*;

	localparam int COORD_W = 12;
	localparam int RAD_W = 11;
	localparam int WDATA_W = 12;
	localparam int PIPE_DEPTH = RAD_W + 4;
	localparam int LONG_HOLD = 64;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_PHASES = 8;
	localparam int ROWS_PER_PHASE = 50;
	// index with no register behind it
	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [13:0] row_y;
		logic [13:0] left_x;
		logic [12:0] right_x;
		logic        outside;
	} span_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [WDATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// bits up: row_offset, zero pad
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// bits up: row_y, left_x, right_x, zero pad
	logic [47:0] m_tdata;
	// bits up: outside
	logic m_tuser;

	circle_fill_span #(
		.COORD_BITS (COORD_W),
		.RADIUS_BITS(RAD_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bench copy of the circle registers
	int center_x_q = 0;
	int center_y_q = 0;
	int radius_q = RADIUS_RESET;

	logic [11:0] row_pending[$];
	span_t span_expected[$];
	int rows_queued = 0;
	int rows_accepted = 0;
	int spans_seen = 0;
	int outside_seen = 0;
	int reg_writes = 0;
	int mismatches = 0;
	int send_gap_max = 0;
	int sink_gap_max = 0;
	int long_hold_reqs = 0;
	int long_hold_done = 0;

	function automatic span_t predict_span(logic [11:0] offset);
		span_t sp;
		int dy, mag, rem, root, trial;
		dy = int'($signed(offset));
		mag = (dy < 0) ? -dy : dy;
		sp = '0;
		if (mag > radius_q) begin
			sp.outside = 1'b1;
		end else begin
			rem = radius_q * radius_q - mag * mag;
			root = 0;
			// exact floor square root, one bit at a time from the top
			for (int b = RAD_W; b >= 0; b--) begin
				trial = root | (1 << b);
				if (trial * trial <= rem)
					root = trial;
			end
			sp.row_y = 14'(center_y_q + dy);
			sp.left_x = 14'(center_x_q - root);
			sp.right_x = 13'(center_x_q + root);
		end
		return sp;
	endfunction

	// driver: offers queued rows, random gap after each transaction
	logic offer_free;
	logic [11:0] offset_in_flight;
	int send_wait;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_wait <= 0;
		end else begin
			offer_free = !s_tvalid;
			if (s_tvalid && s_tready) begin
				span_expected.push_back(predict_span(offset_in_flight));
				rows_accepted++;
				offer_free = 1'b1;
			end
			if (offer_free) begin
				if (send_wait != 0) begin
					send_wait <= send_wait - 1;
					s_tvalid <= 1'b0;
				end else if (row_pending.size() != 0) begin
					offset_in_flight = row_pending.pop_front();
					s_tdata <= 16'(offset_in_flight);
					s_tvalid <= 1'b1;
					send_wait <= $urandom_range(0, send_gap_max);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each span transaction, then draws its own back-pressure
	span_t got, want;
	int sink_wait;
	int next_wait;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_wait <= 0;
		end else begin
			next_wait = sink_wait;
			if (m_tvalid && m_tready) begin
				spans_seen++;
				got.row_y = m_tdata[13:0];
				got.left_x = m_tdata[27:14];
				got.right_x = m_tdata[40:28];
				got.outside = m_tuser;
				if (got.outside)
					outside_seen++;
				if (span_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: span with nothing expected: row %0d left %0d right %0d out %0b",
							$realtime, $signed(got.row_y), $signed(got.left_x), got.right_x,
							got.outside);
				end else begin
					want = span_expected.pop_front();
					if (got.row_y !== want.row_y || got.left_x !== want.left_x ||
					    got.right_x !== want.right_x || got.outside !== want.outside) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: span mismatch exp row %0d left %0d right %0d out %0b, got row %0d left %0d right %0d out %0b",
								$realtime, $signed(want.row_y), $signed(want.left_x),
								want.right_x, want.outside, $signed(got.row_y),
								$signed(got.left_x), got.right_x, got.outside);
					end
				end
				next_wait = $urandom_range(0, sink_gap_max);
			end
			if (long_hold_done != long_hold_reqs) begin
				next_wait = LONG_HOLD;
				long_hold_done++;
			end
			if (next_wait != 0) begin
				m_tready <= 1'b0;
				sink_wait <= next_wait - 1;
			end else begin
				m_tready <= 1'b1;
				sink_wait <= 0;
			end
		end
	end

	// watchdog on cycles without any transaction
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired after %0d quiet cycles", IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [WDATA_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		reg_writes++;
		case (idx)
			REG_CENTER_X: center_x_q = int'(val[COORD_W-1:0]);
			REG_CENTER_Y: center_y_q = int'(val[COORD_W-1:0]);
			REG_RADIUS:   radius_q = int'(val[RAD_W-1:0]);
			default:      ;
		endcase
	endtask

	task automatic queue_row(int dy);
		row_pending.push_back(dy[11:0]);
		rows_queued++;
	endtask

	// sender stops here until every span of the phase is back
	task automatic drain();
		while (spans_seen < rows_queued)
			@(posedge clk);
	endtask

	function automatic int pick_offset(int r);
		int k, dy;
		k = $urandom_range(0, 9);
		if (k < 6) begin
			dy = int'($urandom_range(0, 2 * r)) - r;
		end else if (k < 8) begin
			// right on the rim or one past it
			dy = r + int'($urandom_range(0, 1));
			if ($urandom_range(0, 1) != 0)
				dy = -dy;
		end else begin
			dy = int'($urandom_range(0, 4095)) - 2048;
		end
		return dy;
	endfunction

	task automatic random_config();
		int k;
		k = $urandom_range(0, 3);
		write_reg(REG_CENTER_X, (k == 0) ? 12'd0 : (k == 1) ? 12'hfff : 12'($urandom));
		k = $urandom_range(0, 3);
		write_reg(REG_CENTER_Y, (k == 0) ? 12'd0 : (k == 1) ? 12'hfff : 12'($urandom));
		k = $urandom_range(0, 4);
		case (k)
			0: write_reg(REG_RADIUS, 12'($urandom_range(0, 1)) | 12'($urandom_range(0, 1) << 11));
			1: write_reg(REG_RADIUS, 12'h7ff | 12'($urandom_range(0, 1) << 11));
			2: write_reg(REG_RADIUS, 12'($urandom_range(2, 40)) | 12'($urandom_range(0, 1) << 11));
			default: write_reg(REG_RADIUS, 12'($urandom));
		endcase
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_UNUSED, 12'($urandom));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: centre at the origin, radius 50, left edge goes negative
		@(negedge clk);
		queue_row(0);
		queue_row(50);
		queue_row(-50);
		queue_row(51);
		queue_row(-51);
		queue_row(-2048);
		queue_row(2047);
		queue_row(-2047);
		queue_row(-1);
		queue_row(30);
		drain();

		// far corner with the largest radius
		write_reg(REG_CENTER_X, 12'hfff);
		write_reg(REG_CENTER_Y, 12'hfff);
		write_reg(REG_RADIUS, 12'h7ff);
		@(negedge clk);
		queue_row(0);
		queue_row(2047);
		queue_row(-2047);
		queue_row(-2048);
		queue_row(1000);
		drain();

		// bit above the radius width is dropped, unused index leaves things alone
		write_reg(REG_RADIUS, 12'h805);
		write_reg(REG_UNUSED, 12'h0);
		@(negedge clk);
		queue_row(5);
		queue_row(6);
		queue_row(-5);
		queue_row(3);
		drain();

		// zero radius: single pixel at dy 0 only
		write_reg(REG_CENTER_X, 12'h0);
		write_reg(REG_RADIUS, 12'h0);
		@(negedge clk);
		queue_row(0);
		queue_row(1);
		queue_row(-1);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			random_config();
			@(negedge clk);
			case ($urandom_range(0, 2))
				0: send_gap_max = 0;
				1: send_gap_max = 3;
				default: send_gap_max = 7;
			endcase
			case ($urandom_range(0, 2))
				0: sink_gap_max = 0;
				1: sink_gap_max = 3;
				default: sink_gap_max = 7;
			endcase
			if (ph == 1) begin
				// sender keeps offering while the sink holds off, so the pipe backs up
				send_gap_max = 0;
				long_hold_reqs++;
			end
			for (int n = 0; n < ROWS_PER_PHASE; n++)
				queue_row(pick_offset(radius_q));
			drain();
		end

		// any stray span would show up during this wait
		repeat (3 * PIPE_DEPTH) @(posedge clk);
		if (span_expected.size() != 0) begin
			mismatches += span_expected.size();
			$display("%0d expected spans never arrived", span_expected.size());
		end
		$display("rows sent %0d, spans checked %0d (%0d outside), register writes %0d",
			rows_accepted, spans_seen, outside_seen, reg_writes);
		$display("mismatches %0d", mismatches);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
